// ----- hdl/ring_deque_top_defines.svh -----
// ----------------------------------------------------------------------------
// ring_deque_top_defines
// assertion macros shared by the ring deque rtl
// ----------------------------------------------------------------------------
`ifndef RING_DEQUE_TOP_DEFINES_SVH
`define RING_DEQUE_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define RDQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ring deque check failed");

// antecedent implies consequent in the next cycle
`define RDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ring deque check failed");

// condition holds at every edge out of reset
`define RDQ_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ring deque check failed");

`endif

// ----- hdl/rdq_pkg.sv -----
// ----------------------------------------------------------------------------
// rdq_pkg
// types and constants shared by the ring deque modules
// ----------------------------------------------------------------------------
package rdq_pkg;

    localparam int MODE_W = 3;
    localparam int CFG_W  = 5;
    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [MODE_W-1:0] {
        MODE_QUERY      = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_PUSH_FRONT = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_POP_REAR   = 3'd4
    } mode_t;

    // how an end token moves along the ring of cells
    typedef enum logic [1:0] {
        TOK_HOLD = 2'd0,
        TOK_UP   = 2'd1,
        TOK_DOWN = 2'd2,
        TOK_HOME = 2'd3
    } tok_op_t;

    typedef struct packed {
        tok_op_t front_op;
        tok_op_t rear_op;
        logic    wr_front;
        logic    wr_rear;
    } ctrl_t;

endpackage

// ----- hdl/rdq_cell.sv -----
// ----------------------------------------------------------------------------
// rdq_cell
// one slot of the ring: data word plus front and rear end tokens
// ----------------------------------------------------------------------------
module rdq_cell #(
    parameter int   DATA_WIDTH = 32,
    parameter logic IS_HOME    = 1'b0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rdq_pkg::ctrl_t        ctrl,
    input  logic [DATA_WIDTH-1:0] wdata,
    input  logic                  front_up_in,
    input  logic                  front_down_in,
    input  logic                  rear_up_in,
    input  logic                  rear_down_in,
    output logic                  front_tok,
    output logic                  rear_tok,
    output logic [DATA_WIDTH-1:0] front_part,
    output logic [DATA_WIDTH-1:0] rear_part
);

    logic                  front_tok_reg;
    logic                  front_tok_next;
    logic                  rear_tok_reg;
    logic                  rear_tok_next;
    logic [DATA_WIDTH-1:0] data_reg;
    logic                  wr_hit;

    always_comb
    begin
        case (ctrl.front_op)
            rdq_pkg::TOK_UP:   front_tok_next = front_up_in;
            rdq_pkg::TOK_DOWN: front_tok_next = front_down_in;
            rdq_pkg::TOK_HOME: front_tok_next = IS_HOME;
            default:           front_tok_next = front_tok_reg;
        endcase
    end

    always_comb
    begin
        case (ctrl.rear_op)
            rdq_pkg::TOK_UP:   rear_tok_next = rear_up_in;
            rdq_pkg::TOK_DOWN: rear_tok_next = rear_down_in;
            rdq_pkg::TOK_HOME: rear_tok_next = IS_HOME;
            default:           rear_tok_next = rear_tok_reg;
        endcase
    end

    // the pushed word lands where the moved token arrives
    assign wr_hit = (ctrl.wr_front & front_tok_next) | (ctrl.wr_rear & rear_tok_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_tok_reg <= IS_HOME;
            rear_tok_reg  <= IS_HOME;
        end
        else
        begin
            front_tok_reg <= front_tok_next;
            rear_tok_reg  <= rear_tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            data_reg <= wdata;
        end
    end

    assign front_tok  = front_tok_reg;
    assign rear_tok   = rear_tok_reg;
    assign front_part = data_reg & {DATA_WIDTH{front_tok_reg}};
    assign rear_part  = data_reg & {DATA_WIDTH{rear_tok_reg}};

endmodule

// ----- hdl/rdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// rdq_ctrl
// mode decode, item count, capacity register and result strobe
// ----------------------------------------------------------------------------
module rdq_ctrl #(
    parameter int DEPTH = 16,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fire,
    input  logic [rdq_pkg::MODE_W-1:0] mode,
    input  logic                      cfg_wr_en,
    input  logic [rdq_pkg::CFG_W-1:0] cfg_wr_data,
    output rdq_pkg::ctrl_t            ctrl,
    output logic                      done,
    output logic                      ok,
    output logic [CNT_W-1:0]          count,
    output logic [CNT_W-1:0]          cap
);

    localparam int CMP_W = (CNT_W > rdq_pkg::CFG_W) ? CNT_W : rdq_pkg::CFG_W;

    logic [rdq_pkg::CFG_W-1:0] cap_cfg_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      ok_reg;
    logic                      ok_next;
    logic                      done_reg;
    logic [CMP_W-1:0]          cap_wide;
    logic [CNT_W-1:0]          cap_eff;

    // zero acts as one, anything past the built depth saturates
    always_comb
    begin
        cap_wide = CMP_W'(cap_cfg_reg);
        if (cap_cfg_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (cap_wide > CMP_W'(DEPTH))
        begin
            cap_eff = CNT_W'(DEPTH);
        end
        else
        begin
            cap_eff = CNT_W'(cap_wide);
        end
    end

    always_comb
    begin
        ctrl.front_op = rdq_pkg::TOK_HOLD;
        ctrl.rear_op  = rdq_pkg::TOK_HOLD;
        ctrl.wr_front = 1'b0;
        ctrl.wr_rear  = 1'b0;
        count_next    = count_reg;
        ok_next       = 1'b0;
        if (fire)
        begin
            unique case (rdq_pkg::mode_t'(mode)) inside
                rdq_pkg::MODE_QUERY:
                begin
                    ok_next = 1'b1;
                end
                rdq_pkg::MODE_PUSH_BACK, rdq_pkg::MODE_PUSH_FRONT:
                begin
                    if (count_reg == '0)
                    begin
                        ctrl.front_op = rdq_pkg::TOK_HOME;
                        ctrl.rear_op  = rdq_pkg::TOK_HOME;
                        ctrl.wr_front = 1'b1;
                        count_next    = CNT_W'(1);
                        ok_next       = 1'b1;
                    end
                    else if (count_reg < cap_eff)
                    begin
                        if (rdq_pkg::mode_t'(mode) == rdq_pkg::MODE_PUSH_BACK)
                        begin
                            ctrl.rear_op = rdq_pkg::TOK_DOWN;
                            ctrl.wr_rear = 1'b1;
                        end
                        else
                        begin
                            ctrl.front_op = rdq_pkg::TOK_UP;
                            ctrl.wr_front = 1'b1;
                        end
                        count_next = count_reg + CNT_W'(1);
                        ok_next    = 1'b1;
                    end
                end
                rdq_pkg::MODE_POP_FRONT:
                begin
                    if (count_reg != '0)
                    begin
                        ctrl.front_op = rdq_pkg::TOK_DOWN;
                        count_next    = count_reg - CNT_W'(1);
                        ok_next       = 1'b1;
                    end
                end
                rdq_pkg::MODE_POP_REAR:
                begin
                    if (count_reg != '0)
                    begin
                        ctrl.rear_op = rdq_pkg::TOK_UP;
                        count_next   = count_reg - CNT_W'(1);
                        ok_next      = 1'b1;
                    end
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_cfg_reg <= rdq_pkg::CAP_RESET;
            count_reg   <= '0;
            ok_reg      <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_cfg_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            ok_reg    <= ok_next;
            done_reg  <= fire;
        end
    end

    assign done  = done_reg;
    assign ok    = ok_reg;
    assign count = count_reg;
    assign cap   = cap_eff;

endmodule

// ----- hdl/ring_deque_top.sv -----
// ----------------------------------------------------------------------------
// ring_deque_top
// fixed-capacity double-ended queue held in a ring of slot cells
// ----------------------------------------------------------------------------
// usage
//   command channel: drive mode and push_data with start high; a beat is taken
//   at a clock edge where start is high and busy is low. busy never rises, so
//   a command can be issued in every cycle.
//   result channel: done is high for exactly one cycle, the cycle after the
//   command beat, with accepted, both end words, ends_valid, item_count,
//   is_empty and is_full. the receiver cannot stall this channel.
//   throughput is one command per cycle; the end
//   tokens step one cell along the ring per command and the end words come
//   from a one-hot select over the cells.
//   capacity: cfg_wr_en with cfg_wr_data sets the capacity in use; write it
//   only while no result is pending.
//   reset: the deque is empty, both end tokens sit in cell 0 and the
//   capacity in use is 16. slot words are not cleared.
// ----------------------------------------------------------------------------
`include "ring_deque_top_defines.svh"

module ring_deque_top #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [rdq_pkg::MODE_W-1:0] mode,
    input  logic [DATA_WIDTH-1:0]      push_data,
    input  logic                       cfg_wr_en,
    input  logic [rdq_pkg::CFG_W-1:0]  cfg_wr_data,
    output logic                       done,
    output logic                       accepted,
    output logic [DATA_WIDTH-1:0]      front_data,
    output logic [DATA_WIDTH-1:0]      rear_data,
    output logic                       ends_valid,
    output logic [CNT_W-1:0]           item_count,
    output logic                       is_empty,
    output logic                       is_full
);

    rdq_pkg::ctrl_t        ctrl;
    logic                  fire;
    logic                  ok;
    logic [CNT_W-1:0]      count;
    logic [CNT_W-1:0]      cap;

    logic [DEPTH-1:0]      front_tok;
    logic [DEPTH-1:0]      rear_tok;
    logic [DEPTH-1:0]      over_cap;
    logic [DEPTH-1:0]      last_cap;
    logic [DEPTH-1:0]      front_up_in;
    logic [DEPTH-1:0]      front_down_in;
    logic [DEPTH-1:0]      rear_up_in;
    logic [DEPTH-1:0]      rear_down_in;
    logic                  front_wrap;
    logic                  rear_wrap;
    logic [DATA_WIDTH-1:0] front_part [DEPTH];
    logic [DATA_WIDTH-1:0] rear_part  [DEPTH];
    logic [DATA_WIDTH-1:0] front_rd;
    logic [DATA_WIDTH-1:0] rear_rd;

    assign busy = 1'b0;
    assign fire = start & ~busy;

    rdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .mode        (mode),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ctrl        (ctrl),
        .done        (done),
        .ok          (ok),
        .count       (count),
        .cap         (cap)
    );

    // tokens at or past the last slot in use wrap up to cell 0
    always_comb
    begin
        front_wrap = 1'b0;
        rear_wrap  = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            front_wrap = front_wrap | (front_tok[i] & over_cap[i]);
            rear_wrap  = rear_wrap | (rear_tok[i] & over_cap[i]);
        end
    end

    generate
        for (genvar j = 0; j < DEPTH; j++)
        begin : g_cell
            assign over_cap[j] = (CNT_W'(j + 1) >= cap);
            assign last_cap[j] = (CNT_W'(j + 1) == cap);

            if (j == 0)
            begin : g_up_first
                assign front_up_in[j] = front_wrap;
                assign rear_up_in[j]  = rear_wrap;
            end
            else
            begin : g_up_mid
                assign front_up_in[j] = front_tok[j-1] & ~over_cap[j-1];
                assign rear_up_in[j]  = rear_tok[j-1] & ~over_cap[j-1];
            end

            // cell 0 stepping down lands on the last slot in use
            if (j == DEPTH - 1)
            begin : g_down_last
                assign front_down_in[j] = last_cap[j] & front_tok[0];
                assign rear_down_in[j]  = last_cap[j] & rear_tok[0];
            end
            else
            begin : g_down_mid
                assign front_down_in[j] = front_tok[j+1] | (last_cap[j] & front_tok[0]);
                assign rear_down_in[j]  = rear_tok[j+1] | (last_cap[j] & rear_tok[0]);
            end

            rdq_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .IS_HOME    ((j == 0) ? 1'b1 : 1'b0)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .ctrl          (ctrl),
                .wdata         (push_data),
                .front_up_in   (front_up_in[j]),
                .front_down_in (front_down_in[j]),
                .rear_up_in    (rear_up_in[j]),
                .rear_down_in  (rear_down_in[j]),
                .front_tok     (front_tok[j]),
                .rear_tok      (rear_tok[j]),
                .front_part    (front_part[j]),
                .rear_part     (rear_part[j])
            );
        end
    endgenerate

    always_comb
    begin
        front_rd = '0;
        rear_rd  = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            front_rd = front_rd | front_part[i];
            rear_rd  = rear_rd | rear_part[i];
        end
    end

    assign accepted   = ok;
    assign ends_valid = (count != '0);
    assign front_data = ends_valid ? front_rd : '0;
    assign rear_data  = ends_valid ? rear_rd : '0;
    assign item_count = count;
    assign is_empty   = (count == '0);
    assign is_full    = (count != '0) && (count == cap);

    `RDQ_ASSERT_ALWAYS(a_front_tok_onehot, clk, rst_n, $onehot(front_tok))
    `RDQ_ASSERT_ALWAYS(a_rear_tok_onehot, clk, rst_n, $onehot(rear_tok))
    `RDQ_ASSERT_NEXT(a_count_idle, clk, rst_n, !fire, $stable(item_count))
    `RDQ_ASSERT_SAME(a_full_not_empty, clk, rst_n, is_full, !is_empty)

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for ring_deque_top: a short table of directed commands
// walks the empty, single item, full and refused cases. Random command runs
// follow over a range of capacity settings. Every result beat is compared
// field by field against the shadow deque kept in the bench or a row's typed view.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = 5;

    localparam logic [rdq_pkg::MODE_W-1:0] UNKNOWN_MODE_FIRST = 3'd5;
    localparam logic [rdq_pkg::MODE_W-1:0] UNKNOWN_MODE_MID   = 3'd6;
    localparam logic [rdq_pkg::MODE_W-1:0] UNKNOWN_MODE_LAST  = 3'd7;

    localparam int PHASES         = 12;
    localparam int OPS_PER_PHASE  = 150;
    localparam int UNPAUSED_PHASE = 5;
    localparam int IDLE_PERCENT   = 16;
    localparam int QUIET_LIMIT    = 500;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 40;

    typedef struct packed {
        logic                  accepted;
        logic [DATA_WIDTH-1:0] front_data;
        logic [DATA_WIDTH-1:0] rear_data;
        logic                  ends_valid;
        logic [CNT_W-1:0]      item_count;
        logic                  is_empty;
        logic                  is_full;
    } deque_view_t;

    typedef struct {
        logic [rdq_pkg::MODE_W-1:0] op;
        logic [DATA_WIDTH-1:0]      word;
        bit                         typed;
        deque_view_t                view;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [rdq_pkg::MODE_W-1:0] mode;
    logic [DATA_WIDTH-1:0]      push_data;
    logic                       cfg_wr_en;
    logic [rdq_pkg::CFG_W-1:0]  cfg_wr_data;
    logic                       done;
    logic                       accepted;
    logic [DATA_WIDTH-1:0]      front_data;
    logic [DATA_WIDTH-1:0]      rear_data;
    logic                       ends_valid;
    logic [CNT_W-1:0]           item_count;
    logic                       is_empty;
    logic                       is_full;

    // typed expectation travels with the beat it belongs to
    bit          row_typed;
    deque_view_t row_view;

    // shadow deque
    logic [3:0]                head_idx;
    logic [3:0]                tail_idx;
    logic [CNT_W-1:0]          held_count;
    logic [DATA_WIDTH-1:0]     slot_copy [DEPTH];
    logic [rdq_pkg::CFG_W-1:0] capacity_copy;

    deque_view_t expected_views[$];
    stim_row_t   directed_rows[$];
    logic [rdq_pkg::CFG_W-1:0] cap_plan [PHASES];

    int beats_sent;
    int views_checked;
    int refused_ops;
    int full_views;
    int mismatches;
    int quiet_cycles;
    bit fill_bias;
    int tilt_left;

    ring_deque_top #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .push_data   (push_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .accepted    (accepted),
        .front_data  (front_data),
        .rear_data   (rear_data),
        .ends_valid  (ends_valid),
        .item_count  (item_count),
        .is_empty    (is_empty),
        .is_full     (is_full)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [3:0] ring_step_up(logic [3:0] idx, logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] nxt;
        nxt = {1'b0, idx} + 1'b1;
        return (nxt >= cap) ? 4'd0 : nxt[3:0];
    endfunction

    function automatic logic [3:0] ring_step_down(logic [3:0] idx, logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] prev;
        prev = cap - 1'b1;
        return (idx == 4'd0) ? prev[3:0] : idx - 1'b1;
    endfunction

    // applies one command to the shadow deque and returns what the block should show
    function deque_view_t apply_deque_op(logic [rdq_pkg::MODE_W-1:0] op,
                                         logic [DATA_WIDTH-1:0] word);
        deque_view_t      v;
        logic [CNT_W-1:0] cap;
        logic             ok;
        cap = capacity_copy;
        if (cap == '0)
            cap = 5'd1;
        if (cap > CNT_W'(DEPTH))
            cap = CNT_W'(DEPTH);
        ok = 1'b0;
        case (op) inside
            rdq_pkg::MODE_QUERY:
                ok = 1'b1;
            rdq_pkg::MODE_PUSH_BACK, rdq_pkg::MODE_PUSH_FRONT:
            begin
                if (held_count == '0)
                begin
                    head_idx = 4'd0;
                    tail_idx = 4'd0;
                    slot_copy[0] = word;
                    held_count = 5'd1;
                    ok = 1'b1;
                end
                else if (held_count < cap)
                begin
                    if (op == rdq_pkg::MODE_PUSH_BACK)
                    begin
                        tail_idx = ring_step_down(tail_idx, cap);
                        slot_copy[tail_idx] = word;
                    end
                    else
                    begin
                        head_idx = ring_step_up(head_idx, cap);
                        slot_copy[head_idx] = word;
                    end
                    held_count = held_count + 1'b1;
                    ok = 1'b1;
                end
            end
            rdq_pkg::MODE_POP_FRONT, rdq_pkg::MODE_POP_REAR:
            begin
                if (held_count != '0)
                begin
                    if (op == rdq_pkg::MODE_POP_FRONT)
                        head_idx = ring_step_down(head_idx, cap);
                    else
                        tail_idx = ring_step_up(tail_idx, cap);
                    held_count = held_count - 1'b1;
                    ok = 1'b1;
                end
            end
            default:
                ok = 1'b0;
        endcase
        v.accepted   = ok;
        v.ends_valid = (held_count != '0);
        v.front_data = v.ends_valid ? slot_copy[head_idx] : '0;
        v.rear_data  = v.ends_valid ? slot_copy[tail_idx] : '0;
        v.item_count = held_count;
        v.is_empty   = !v.ends_valid;
        v.is_full    = v.ends_valid && (held_count == cap);
        if (!ok)
            refused_ops++;
        if (v.is_full)
            full_views++;
        return v;
    endfunction

    function automatic deque_view_t empty_view(logic ok);
        deque_view_t v;
        v = '0;
        v.accepted = ok;
        v.is_empty = 1'b1;
        return v;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns  mismatch: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [DATA_WIDTH-1:0] got,
                               logic [DATA_WIDTH-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %h want %h",
                                      views_checked, name, got, want));
    endtask

    task automatic compare_view(deque_view_t got, deque_view_t want);
        check_field("accepted", DATA_WIDTH'(got.accepted), DATA_WIDTH'(want.accepted));
        check_field("front_data", got.front_data, want.front_data);
        check_field("rear_data", got.rear_data, want.rear_data);
        check_field("ends_valid", DATA_WIDTH'(got.ends_valid), DATA_WIDTH'(want.ends_valid));
        check_field("item_count", DATA_WIDTH'(got.item_count), DATA_WIDTH'(want.item_count));
        check_field("is_empty", DATA_WIDTH'(got.is_empty), DATA_WIDTH'(want.is_empty));
        check_field("is_full", DATA_WIDTH'(got.is_full), DATA_WIDTH'(want.is_full));
    endtask

    // result beats first, then register writes, then the new command beat
    always @(posedge clk)
    begin
        deque_view_t got;
        deque_view_t want;
        if (rst_n)
        begin
            if (done)
            begin
                got.accepted   = accepted;
                got.front_data = front_data;
                got.rear_data  = rear_data;
                got.ends_valid = ends_valid;
                got.item_count = item_count;
                got.is_empty   = is_empty;
                got.is_full    = is_full;
                if (expected_views.size() == 0)
                    report_mismatch("result beat with nothing pending");
                else
                begin
                    want = expected_views.pop_front();
                    compare_view(got, want);
                    views_checked++;
                end
            end
            if (cfg_wr_en)
                capacity_copy = cfg_wr_data;
            if (start && !busy)
            begin
                want = apply_deque_op(mode, push_data);
                if (row_typed)
                    want = row_view;
                expected_views.push_back(want);
                beats_sent++;
            end
            if (done || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    task automatic send_beat(logic [rdq_pkg::MODE_W-1:0] op, logic [DATA_WIDTH-1:0] word,
                             bit typed, deque_view_t view);
        @(negedge clk);
        start     <= 1'b1;
        mode      <= op;
        push_data <= word;
        row_typed <= typed;
        row_view  <= view;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic hold_off();
        @(negedge clk);
        start     <= 1'b0;
        row_typed <= 1'b0;
        mode      <= rdq_pkg::MODE_W'($urandom);
        push_data <= $urandom;
    endtask

    // stop issuing and wait out every pending result
    task automatic drain();
        hold_off();
        while (expected_views.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_capacity(logic [rdq_pkg::CFG_W-1:0] cap);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= rdq_pkg::CFG_W'($urandom);
    endtask

    task automatic add_row(logic [rdq_pkg::MODE_W-1:0] op, logic [DATA_WIDTH-1:0] word,
                           bit typed, deque_view_t view);
        stim_row_t r;
        r.op    = op;
        r.word  = word;
        r.typed = typed;
        r.view  = view;
        directed_rows.push_back(r);
    endtask

    // runs alternate between filling and draining so both ends wrap and fill up
    task automatic send_random_op();
        int                         roll;
        logic [rdq_pkg::MODE_W-1:0] op;
        logic [DATA_WIDTH-1:0]      word;
        if (tilt_left == 0)
        begin
            fill_bias = !fill_bias;
            tilt_left = $urandom_range(8, 40);
        end
        tilt_left--;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            op = rdq_pkg::MODE_W'($urandom_range(UNKNOWN_MODE_FIRST, UNKNOWN_MODE_LAST));
        else if (roll < 10)
            op = rdq_pkg::MODE_QUERY;
        else if ($urandom_range(0, 99) < (fill_bias ? 75 : 25))
            op = $urandom_range(0, 1) ? rdq_pkg::MODE_PUSH_BACK : rdq_pkg::MODE_PUSH_FRONT;
        else
            op = $urandom_range(0, 1) ? rdq_pkg::MODE_POP_FRONT : rdq_pkg::MODE_POP_REAR;
        roll = $urandom_range(0, 15);
        if (roll == 0)
            word = '0;
        else if (roll == 1)
            word = '1;
        else
            word = $urandom;
        send_beat(op, word, 1'b0, '0);
    endtask

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("watchdog: no beat for %0d cycles, %0d results pending",
                 QUIET_LIMIT, expected_views.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        deque_view_t first_push;
        int          k;

        rst_n       = 1'b0;
        start       = 1'b0;
        mode        = rdq_pkg::MODE_QUERY;
        push_data   = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        row_typed   = 1'b0;
        row_view    = '0;

        head_idx      = '0;
        tail_idx      = '0;
        held_count    = '0;
        capacity_copy = rdq_pkg::CAP_RESET;
        for (k = 0; k < DEPTH; k++)
            slot_copy[k] = '0;

        beats_sent    = 0;
        views_checked = 0;
        refused_ops   = 0;
        full_views    = 0;
        mismatches    = 0;
        quiet_cycles  = 0;
        fill_bias     = 1'b1;
        tilt_left     = 0;

        cap_plan = '{rdq_pkg::CAP_RESET, 5'd1, 5'd0, 5'd31, 5'd2, 5'd16,
                     5'd7, 5'd17, 5'd3, 5'd12, 5'd16, 5'd5};

        first_push            = '0;
        first_push.accepted   = 1'b1;
        first_push.front_data = '1;
        first_push.rear_data  = '1;
        first_push.ends_valid = 1'b1;
        first_push.item_count = 5'd1;

        // empty deque: query, both pops refused, unknown modes refused, then the first pushes
        add_row(rdq_pkg::MODE_QUERY, 32'h0000_0000, 1'b1, empty_view(1'b1));
        add_row(rdq_pkg::MODE_POP_FRONT, 32'h0000_0000, 1'b1, empty_view(1'b0));
        add_row(rdq_pkg::MODE_POP_REAR, 32'hFFFF_FFFF, 1'b1, empty_view(1'b0));
        add_row(UNKNOWN_MODE_FIRST, 32'hFFFF_FFFF, 1'b1, empty_view(1'b0));
        add_row(UNKNOWN_MODE_LAST, 32'h0000_0000, 1'b1, empty_view(1'b0));
        add_row(rdq_pkg::MODE_PUSH_BACK, 32'hFFFF_FFFF, 1'b1, first_push);
        add_row(rdq_pkg::MODE_PUSH_FRONT, 32'h0000_0000, 1'b0, '0);
        // fill to full capacity, which also writes every slot once
        for (k = 0; k < 14; k++)
            add_row((k % 2) ? rdq_pkg::MODE_PUSH_FRONT : rdq_pkg::MODE_PUSH_BACK,
                    32'h8000_0001 ^ (32'h1 << (k * 2)) ^ (32'h3 << (k + 8)), 1'b0, '0);
        add_row(rdq_pkg::MODE_PUSH_BACK, 32'hA5A5_A5A5, 1'b0, '0);
        add_row(rdq_pkg::MODE_POP_FRONT, 32'h0000_0000, 1'b0, '0);
        add_row(rdq_pkg::MODE_POP_REAR, 32'h0000_0000, 1'b0, '0);
        add_row(UNKNOWN_MODE_MID, 32'h5A5A_5A5A, 1'b0, '0);

        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_beat(directed_rows[i].op, directed_rows[i].word,
                      directed_rows[i].typed, directed_rows[i].view);

        // capacity changes land on a deque that still holds items
        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(cap_plan[p]);
            for (int n = 0; n < OPS_PER_PHASE; n++)
            begin
                if (p != UNPAUSED_PHASE)
                    while ($urandom_range(0, 99) < IDLE_PERCENT)
                        hold_off();
                send_random_op();
            end
        end

        drain();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (expected_views.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_views.size()));

        $display("ring deque: %0d commands over %0d capacity settings, %0d results checked",
                 beats_sent, PHASES, views_checked);
        $display("ring deque: %0d refused commands, %0d results at full, %0d mismatches",
                 refused_ops, full_views, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
